/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files. Both macros sample on the
// rising edge of clk and are quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/xec_pkg.sv */
// ----------------------------------------------------------------------------
// xec_pkg
// Widths and types shared by the entity and CDATA unescaper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package xec_pkg;

	localparam int CW        = 21;	// character code width
	localparam int WIN_DEPTH = 9;	// lookahead window entries
	localparam int FILL_W    = 4;	// window fill count width
	localparam int TDATA_W   = 24;	// stream data width, whole bytes

	// Lookahead window, entry 0 is the head.
	typedef logic [WIN_DEPTH-1:0][CW-1:0] win_t;

	// One result word as it travels through the queue.
	typedef struct packed {
		logic [CW-1:0] ch;
		logic          no_char;
		logic          last;
	} res_t;

endpackage

`default_nettype wire

/* rtl/xec_front.sv */
// ----------------------------------------------------------------------------
// xec_front
// Lookahead window and token decoder. Appends incoming characters, decodes
// one token whenever the window fills, and drains the window after the final
// character of a text.
// ----------------------------------------------------------------------------
`default_nettype none

module xec_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [xec_pkg::CW-1:0] in_char,
	input  logic                  in_last,
	output logic                  push,
	output xec_pkg::res_t         push_res,
	input  logic                  q_full
);
	import xec_pkg::*;

	typedef struct packed {
		logic              emit;
		logic [CW-1:0]     ch;
		logic [FILL_W-1:0] n;
		logic              cdata;
	} dec_t;

	localparam logic [CW-1:0] CH_EXCL  = CW'(8'h21);
	localparam logic [CW-1:0] CH_QUOT  = CW'(8'h22);
	localparam logic [CW-1:0] CH_HASH  = CW'(8'h23);
	localparam logic [CW-1:0] CH_AMP   = CW'(8'h26);
	localparam logic [CW-1:0] CH_APOS  = CW'(8'h27);
	localparam logic [CW-1:0] CH_0     = CW'(8'h30);
	localparam logic [CW-1:0] CH_9     = CW'(8'h39);
	localparam logic [CW-1:0] CH_SEMI  = CW'(8'h3B);
	localparam logic [CW-1:0] CH_LT    = CW'(8'h3C);
	localparam logic [CW-1:0] CH_GT    = CW'(8'h3E);
	localparam logic [CW-1:0] CH_UA    = CW'(8'h41);
	localparam logic [CW-1:0] CH_UC    = CW'(8'h43);
	localparam logic [CW-1:0] CH_UD    = CW'(8'h44);
	localparam logic [CW-1:0] CH_UT    = CW'(8'h54);
	localparam logic [CW-1:0] CH_LBRK  = CW'(8'h5B);
	localparam logic [CW-1:0] CH_RBRK  = CW'(8'h5D);
	localparam logic [CW-1:0] CH_LA    = CW'(8'h61);
	localparam logic [CW-1:0] CH_LG    = CW'(8'h67);
	localparam logic [CW-1:0] CH_LL    = CW'(8'h6C);
	localparam logic [CW-1:0] CH_LM    = CW'(8'h6D);
	localparam logic [CW-1:0] CH_LO    = CW'(8'h6F);
	localparam logic [CW-1:0] CH_LP    = CW'(8'h70);
	localparam logic [CW-1:0] CH_LQ    = CW'(8'h71);
	localparam logic [CW-1:0] CH_LS    = CW'(8'h73);
	localparam logic [CW-1:0] CH_LT_T  = CW'(8'h74);
	localparam logic [CW-1:0] CH_LU    = CW'(8'h75);

	localparam logic [CW-1:0] Z = '0;

	// Patterns, first character in entry 0.
	localparam win_t PAT_COPEN = {CH_LBRK, CH_UA, CH_UT, CH_UA, CH_UD, CH_UC,
		CH_LBRK, CH_EXCL, CH_LT};
	localparam win_t PAT_CEND  = {Z, Z, Z, Z, Z, Z, CH_GT, CH_RBRK, CH_RBRK};
	localparam win_t PAT_LT    = {Z, Z, Z, Z, Z, CH_SEMI, CH_LT_T, CH_LL, CH_AMP};
	localparam win_t PAT_GT    = {Z, Z, Z, Z, Z, CH_SEMI, CH_LT_T, CH_LG, CH_AMP};
	localparam win_t PAT_AMP   = {Z, Z, Z, Z, CH_SEMI, CH_LP, CH_LM, CH_LA, CH_AMP};
	localparam win_t PAT_QUOT  = {Z, Z, Z, CH_SEMI, CH_LT_T, CH_LO, CH_LU, CH_LQ,
		CH_AMP};
	localparam win_t PAT_APOS  = {Z, Z, Z, CH_SEMI, CH_LS, CH_LO, CH_LP, CH_LA,
		CH_AMP};

	// A pattern matches only when all of its characters are in the window.
	function automatic logic head_is(input win_t w, input logic [FILL_W-1:0] f,
		input win_t p, input logic [FILL_W-1:0] len);
		logic ok;
		ok = (len <= f);
		for (int k = 0; k < WIN_DEPTH; k++) begin
			if (FILL_W'(k) < len && w[k] != p[k]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic dec_t decode(input win_t w, input logic [FILL_W-1:0] f,
		input logic in_cd);
		dec_t              d;
		logic              run;
		logic [FILL_W-1:0] nd;
		logic [13:0]       val;
		d.emit  = 1'b1;
		d.ch    = w[0];
		d.n     = FILL_W'(1);
		d.cdata = in_cd;
		if (in_cd) begin
			if (head_is(w, f, PAT_CEND, FILL_W'(3))) begin
				d.emit  = 1'b0;
				d.n     = FILL_W'(3);
				d.cdata = 1'b0;
			end
		end else if (head_is(w, f, PAT_COPEN, FILL_W'(9))) begin
			d.emit  = 1'b0;
			d.n     = FILL_W'(9);
			d.cdata = 1'b1;
		end else if (w[0] == CH_AMP) begin
			if (f >= FILL_W'(7) && w[1] == CH_HASH) begin
				// Numeric reference: up to four decimal digits, then one
				// more character is dropped.
				run = 1'b1;
				nd  = '0;
				val = '0;
				for (int k = 0; k < 4; k++) begin
					if (run && (w[2+k] inside {[CH_0:CH_9]})) begin
						val = (val << 3) + (val << 1) + {10'd0, w[2+k][3:0]};
						nd  = nd + FILL_W'(1);
					end else begin
						run = 1'b0;
					end
				end
				d.ch = CW'(val);
				d.n  = nd + FILL_W'(3);
			end else if (head_is(w, f, PAT_LT, FILL_W'(4))) begin
				d.ch = CH_LT;
				d.n  = FILL_W'(4);
			end else if (head_is(w, f, PAT_GT, FILL_W'(4))) begin
				d.ch = CH_GT;
				d.n  = FILL_W'(4);
			end else if (head_is(w, f, PAT_AMP, FILL_W'(5))) begin
				d.ch = CH_AMP;
				d.n  = FILL_W'(5);
			end else if (head_is(w, f, PAT_QUOT, FILL_W'(6))) begin
				d.ch = CH_QUOT;
				d.n  = FILL_W'(6);
			end else if (head_is(w, f, PAT_APOS, FILL_W'(6))) begin
				d.ch = CH_APOS;
				d.n  = FILL_W'(6);
			end
		end
		return d;
	endfunction

	win_t              win_q;
	logic [FILL_W-1:0] fill_q;
	logic              cdata_q;
	logic              flush_q;
	logic [CW-1:0]     pend_ch_q;
	logic              pend_vld_q;

	win_t              win_app;
	logic [FILL_W-1:0] fill_app;
	win_t              dec_win;
	logic [FILL_W-1:0] dec_fill;
	dec_t              dec;
	win_t              win_sh;
	logic              accept;
	logic              step_norm;
	logic              step_fl;
	logic              fin;

	assign in_ready = !flush_q && !q_full;
	assign accept   = in_valid && in_ready;
	assign fill_app = fill_q + FILL_W'(1);

	always_comb begin
		win_app = win_q;
		win_app[fill_q] = in_char;
	end

	// One decoder serves both the streaming step and the drain.
	assign dec_win  = flush_q ? win_q : win_app;
	assign dec_fill = flush_q ? fill_q : fill_app;
	assign dec      = decode(dec_win, dec_fill, cdata_q);

	// Drop the consumed characters from the head, zeros enter at the tail.
	always_comb begin
		logic [FILL_W:0] src;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			src = (FILL_W+1)'(i) + {1'b0, dec.n};
			win_sh[i] = (src < (FILL_W+1)'(WIN_DEPTH)) ? dec_win[src[FILL_W-1:0]] : '0;
		end
	end

	assign step_norm = accept && !in_last && fill_app == FILL_W'(WIN_DEPTH);
	assign step_fl   = flush_q && !q_full && fill_q != '0;
	assign fin       = flush_q && !q_full && fill_q == '0;

	// While draining, the newest result waits in pend until it is known
	// whether another one follows, so the final one can carry last.
	always_comb begin
		push     = 1'b0;
		push_res = '{ch: dec.ch, no_char: 1'b0, last: 1'b0};
		if (step_norm) begin
			push = dec.emit;
		end else if (step_fl) begin
			push     = dec.emit && pend_vld_q;
			push_res = '{ch: pend_ch_q, no_char: 1'b0, last: 1'b0};
		end else if (fin) begin
			push = 1'b1;
			if (pend_vld_q) begin
				push_res = '{ch: pend_ch_q, no_char: 1'b0, last: 1'b1};
			end else begin
				push_res = '{ch: '0, no_char: 1'b1, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			fill_q     <= '0;
			cdata_q    <= 1'b0;
			flush_q    <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				win_q      <= win_app;
				fill_q     <= fill_app;
				flush_q    <= 1'b1;
				pend_vld_q <= 1'b0;
			end else if (step_norm) begin
				win_q   <= win_sh;
				fill_q  <= fill_app - dec.n;
				cdata_q <= dec.cdata;
			end else begin
				win_q  <= win_app;
				fill_q <= fill_app;
			end
		end else if (step_fl) begin
			win_q   <= win_sh;
			fill_q  <= fill_q - dec.n;
			cdata_q <= dec.cdata;
			if (dec.emit) begin
				pend_vld_q <= 1'b1;
			end
		end else if (fin) begin
			win_q      <= '0;
			flush_q    <= 1'b0;
			cdata_q    <= 1'b0;
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fl && dec.emit) begin
			pend_ch_q <= dec.ch;
		end
	end

endmodule

`default_nettype wire

/* rtl/xec_fifo.sv */
// ----------------------------------------------------------------------------
// xec_fifo
// Short result queue between the decoder and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xec_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xec_pkg::res_t din,
	output logic          full,
	input  logic          pop,
	output xec_pkg::res_t dout,
	output logic          empty
);
	import xec_pkg::*;

	localparam int PW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	res_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CNTW-1:0] cnt_q;

	assign full  = cnt_q == CNTW'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

/* rtl/xec_back.sv */
// ----------------------------------------------------------------------------
// xec_back
// Output register that pulls results from the queue and holds them for the
// downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module xec_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  xec_pkg::res_t q_dout,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output xec_pkg::res_t out_res
);
	import xec_pkg::*;

	logic vld_q;
	res_t res_q;

	assign q_pop     = !q_empty && (!vld_q || out_ready);
	assign out_valid = vld_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (q_pop) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= q_dout;
		end
	end

endmodule

`default_nettype wire

/* rtl/xml_entity_cdata_unescaper.sv */
// ----------------------------------------------------------------------------
// xml_entity_cdata_unescaper
// Stream unescaper for XML text: drops CDATA markers, decodes the five named
// entities and short decimal references, and passes other characters on.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)         | tuser   | tlast
//  --------+-----------+----------------------------+---------+----------
//  s_*     | in        | char_code[20:0], zero pad  | -       | last_char
//  m_*     | out       | out_char[20:0], zero pad   | no_char | out_last
//
// Flow: one character word is taken per cycle while the text is open and the
// queue has room. The final word of a text starts a drain of the nine-entry
// window through the single token decoder, one token per cycle while the queue
// has room, and then closes the text; the input pauses until the text is closed.
// Reset: arst_n clears the window, the CDATA flag, the queue and the output
// register's valid flag at once; no sweep follows.
// Stalls: a four-word queue sits between the decoder and the output
// register. Outside the drain, the decoder stops taking words only when that
// queue is full.
//
`default_nettype none

module xml_entity_cdata_unescaper #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [xec_pkg::TDATA_W-1:0] s_tdata,	// char_code[20:0], zeros above
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [xec_pkg::TDATA_W-1:0] m_tdata,	// out_char[20:0], zeros above
	output logic                       m_tuser,	// no_char
	output logic                       m_tlast
);
	import xec_pkg::*;

	// Front to queue.
	logic push;
	res_t push_res;
	logic q_full;

	// Queue to back.
	logic q_pop;
	res_t q_dout;
	logic q_empty;

	res_t out_res;

	// The front owns the window and the decoder. Input bits above the
	// character code are ignored.
	xec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata[CW-1:0]),
		.in_last  (s_tlast),
		.push     (push),
		.push_res (push_res),
		.q_full   (q_full)
	);

	xec_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_res),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	// The back is a single output register, so a waiting result never
	// blocks the decoder while the queue has room.
	xec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_dout    (q_dout),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(TDATA_W - CW){1'b0}}, out_res.ch};
	assign m_tuser = out_res.no_char;
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

/* rtl/xec_checker.sv */
// ----------------------------------------------------------------------------
// xec_checker
// Port-level checks for the unescaper, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module xec_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [xec_pkg::TDATA_W-1:0] s_tdata,
	input logic                        s_tlast,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [xec_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tuser,
	input logic                        m_tlast
);
	import xec_pkg::*;

	// A stalled result word must hold still.
	`ASSERT_AT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")

	// An empty-text marker closes the text and carries no character.
	`ASSERT_AT(a_nochar_form, m_tvalid && m_tuser |-> m_tlast && m_tdata == '0, "empty-text word malformed")

	// Output bits above the character code stay zero.
	`ASSERT_NEVER(a_out_pad, m_tvalid && m_tdata[TDATA_W-1:CW] != '0, "output pad bits set")

	// The window drains after a final word, so the input pauses next cycle.
	`ASSERT_AT(a_drain_pause, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken during drain")

endmodule

bind xml_entity_cdata_unescaper xec_checker u_xec_checker (.*);

`default_nettype wire
